[sv/bmad_pkg.sv]
package bmad_pkg;

  localparam int WORD_W    = 15;
  localparam int ER_AW     = 11;
  localparam int ER_DEPTH  = 2048;
  localparam int FX_IDX_W  = 16;
  localparam int BANK_W    = 6;
  localparam logic [14:0] REG_LAST = 15'o17;
  localparam logic [14:0] ER_LAST  = 15'o1777;
  localparam logic [14:0] FF_LAST  = 15'o3777;
  localparam logic [14:0] FF0_LAST = 15'o2777;
  localparam logic [14:0] MAP_LAST = 15'o7777;
  localparam logic [7:0]  FB_CLAMP = 8'd33;
  localparam logic [5:0]  FB_BASE  = 6'd2;

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_FETCH     = 3'd2,
    MODE_REG_READ  = 3'd3,
    MODE_REG_WRITE = 3'd4,
    MODE_ROM_LOAD  = 3'd5,
    MODE_SET_IN    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    REGION_REG     = 3'd0,
    REGION_ERASE   = 3'd1,
    REGION_FIXFIX  = 3'd2,
    REGION_BANKFIX = 3'd3,
    REGION_INVALID = 3'd4
  } region_t;

  typedef enum logic [3:0] {
    REG_ACC  = 4'd0,
    REG_LINK = 4'd1,
    REG_AUX  = 4'd2,
    REG_EB   = 4'd3,
    REG_FB   = 4'd4,
    REG_PC   = 4'd5,
    REG_BB   = 4'd6,
    REG_NONE = 4'd7
  } reg_id_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_ERASE = 2'd1,
    SRC_FIXED = 2'd2
  } src_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] address;
    logic [15:0] write_value;
    logic [15:0] rom_index;
  } in_item_t;

  typedef struct packed {
    logic [14:0] read_data;
    logic [2:0]  region;
    logic [5:0]  bank_used;
    logic        out_strobe;
    logic [2:0]  out_channel;
    logic [14:0] out_value;
  } out_item_t;

  typedef struct packed {
    logic              er_we;
    logic              er_re;
    logic [ER_AW-1:0]  er_addr;
    logic              fx_we;
    logic              fx_re;
    logic [FX_IDX_W-1:0] fx_addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              reg_we;
    logic              chan_we;
    logic [3:0]        addr;
    logic [2:0]        chan_idx;
    logic [WORD_W-1:0] wdata;
  } reg_req_t;

endpackage

[sv/banked_memory_address_decoder.sv]
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid, in_ready   | bmad_pkg::in_item_t
// out_    | output    | out_valid, out_ready | bmad_pkg::out_item_t
//
// Each item passes through ST_IDLE and ST_LOOK: the decode and memory access in the
// accept cycle, then the registered read data of the single-port store in ST_LOOK.
// After reset the block sweeps both stores to zero, with in_ready low until the
// cycle after the sweep ends; the erasable store is cleared in the same sweep.
// A result waits in the output register; the next item is accepted meanwhile
// and holds in ST_LOOK until that register frees up.
module banked_memory_address_decoder #(
  parameter int NUM_FIXED_BANKS = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmad_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bmad_pkg::out_item_t out_data
);

  localparam int FX_DEPTH = NUM_FIXED_BANKS * 1024;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  bmad_pkg::out_item_t   pend_r, pend_nxt;
  bmad_pkg::src_t        src_r, src_nxt;
  bmad_pkg::out_item_t   out_data_r, out_data_nxt;
  logic                  out_valid_r, out_valid_nxt;

  bmad_pkg::mem_req_t    mreq;
  bmad_pkg::reg_req_t    rreq;
  logic [14:0]           er_rdata, fx_rdata, reg_rdata, eb, fb;
  logic                  mem_busy;

  logic                  accept;
  logic                  out_free;
  logic [14:0]           a;
  logic [14:0]           v;
  logic                  eb_bit;
  logic [7:0]            fb8;
  logic [5:0]            fbank;
  logic [16:0]           fx_lin;

  bmad_mem #(
    .NUM_FIXED_BANKS(NUM_FIXED_BANKS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .er_rdata(er_rdata),
    .fx_rdata(fx_rdata),
    .busy    (mem_busy)
  );

  bmad_regs u_regs (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rreq),
    .rdata(reg_rdata),
    .eb   (eb),
    .fb   (fb)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign a        = in_data.address;
  assign v        = in_data.write_value[14:0];
  assign eb_bit   = a[9] ? eb[1] : eb[0];
  assign fb8      = (fb[7:0] > bmad_pkg::FB_CLAMP) ? bmad_pkg::FB_CLAMP : fb[7:0];

  always_comb begin
    if (a <= bmad_pkg::FF0_LAST) begin
      fbank = 6'd0;
    end else if (a <= bmad_pkg::FF_LAST) begin
      fbank = 6'd1;
    end else begin
      fbank = fb8[5:0] + bmad_pkg::FB_BASE;
    end
  end

  assign fx_lin = {1'b0, fbank, 1'b0, a[8:0]};

  always_comb begin
    pend_nxt     = '0;
    pend_nxt.region = bmad_pkg::REGION_INVALID;
    src_nxt      = bmad_pkg::SRC_NONE;
    mreq         = '0;
    mreq.wdata   = v;
    mreq.er_addr = {eb_bit, a[9:0]};
    mreq.fx_addr = fx_lin[15:0];
    rreq         = '0;
    rreq.addr    = a[3:0];
    rreq.chan_idx = a[2:0];
    rreq.wdata   = v;
    unique case (bmad_pkg::mode_t'(in_data.mode))
      bmad_pkg::MODE_READ, bmad_pkg::MODE_WRITE, bmad_pkg::MODE_FETCH: begin
        if (a <= bmad_pkg::REG_LAST && in_data.mode != bmad_pkg::MODE_FETCH) begin
          pend_nxt.region = bmad_pkg::REGION_REG;
          if (in_data.mode == bmad_pkg::MODE_READ) begin
            pend_nxt.read_data = reg_rdata;
          end
        end else if (a <= bmad_pkg::ER_LAST) begin
          pend_nxt.region    = bmad_pkg::REGION_ERASE;
          pend_nxt.bank_used = {5'd0, eb_bit};
          if (in_data.mode == bmad_pkg::MODE_WRITE) begin
            mreq.er_we = accept;
          end else begin
            mreq.er_re = accept;
            src_nxt    = bmad_pkg::SRC_ERASE;
          end
        end else if (a <= bmad_pkg::MAP_LAST) begin
          pend_nxt.region    = (a <= bmad_pkg::FF_LAST) ? bmad_pkg::REGION_FIXFIX
                                                        : bmad_pkg::REGION_BANKFIX;
          pend_nxt.bank_used = fbank;
          if (in_data.mode != bmad_pkg::MODE_WRITE
              && {1'b0, fx_lin} < 18'(FX_DEPTH)) begin
            mreq.fx_re = accept;
            src_nxt    = bmad_pkg::SRC_FIXED;
          end
        end
      end
      bmad_pkg::MODE_REG_READ, bmad_pkg::MODE_REG_WRITE: begin
        if (a <= bmad_pkg::REG_LAST) begin
          pend_nxt.region = bmad_pkg::REGION_REG;
          if (in_data.mode == bmad_pkg::MODE_REG_READ) begin
            pend_nxt.read_data = reg_rdata;
          end else begin
            rreq.reg_we = accept;
            if (a[3]) begin
              pend_nxt.out_strobe  = 1'b1;
              pend_nxt.out_channel = a[2:0];
              pend_nxt.out_value   = v;
            end
          end
        end
      end
      bmad_pkg::MODE_ROM_LOAD: begin
        mreq.fx_addr = in_data.rom_index;
        if ({2'b00, in_data.rom_index} < 18'(FX_DEPTH)) begin
          mreq.fx_we = accept;
        end
      end
      bmad_pkg::MODE_SET_IN: begin
        rreq.chan_we = accept;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        if (!mem_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          out_data_nxt = pend_r;
          unique case (src_r)
            bmad_pkg::SRC_ERASE: out_data_nxt.read_data = er_rdata;
            bmad_pkg::SRC_FIXED: out_data_nxt.read_data = fx_rdata;
            default:             out_data_nxt.read_data = pend_r.read_data;
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      pend_r <= pend_nxt;
      src_r  <= src_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/bmad_regs.sv]
module bmad_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmad_pkg::reg_req_t                  req,
  output logic [bmad_pkg::WORD_W-1:0]         rdata,
  output logic [bmad_pkg::WORD_W-1:0]         eb,
  output logic [bmad_pkg::WORD_W-1:0]         fb
);

  logic [bmad_pkg::WORD_W-1:0] cpu_r [7];
  logic [bmad_pkg::WORD_W-1:0] in_chan_r [8];
  logic [bmad_pkg::WORD_W-1:0] out_chan_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) cpu_r[i] <= '0;
      for (int i = 0; i < 8; i++) begin
        in_chan_r[i]  <= '0;
        out_chan_r[i] <= '0;
      end
    end else begin
      if (req.reg_we) begin
        if (req.addr[3]) begin
          out_chan_r[req.addr[2:0]] <= req.wdata;
        end else if (req.addr[2:0] != 3'(bmad_pkg::REG_NONE)) begin
          cpu_r[req.addr[2:0]] <= req.wdata;
        end
      end
      if (req.chan_we) begin
        in_chan_r[req.chan_idx] <= req.wdata;
      end
    end
  end

  always_comb begin
    if (req.addr[3]) begin
      rdata = in_chan_r[req.addr[2:0]];
    end else if (req.addr[2:0] == 3'(bmad_pkg::REG_NONE)) begin
      rdata = '0;
    end else begin
      rdata = cpu_r[req.addr[2:0]];
    end
  end

  assign eb = cpu_r[3'(bmad_pkg::REG_EB)];
  assign fb = cpu_r[3'(bmad_pkg::REG_FB)];

endmodule

[sv/bmad_mem.sv]
module bmad_mem #(
  parameter int NUM_FIXED_BANKS = 36
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmad_pkg::mem_req_t          req,
  output logic [bmad_pkg::WORD_W-1:0] er_rdata,
  output logic [bmad_pkg::WORD_W-1:0] fx_rdata,
  output logic                        busy
);

  localparam int FX_DEPTH = NUM_FIXED_BANKS * 1024;
  localparam int FX_AW    = $clog2(FX_DEPTH);

  logic [bmad_pkg::WORD_W-1:0] er_mem [bmad_pkg::ER_DEPTH];
  logic [bmad_pkg::WORD_W-1:0] fx_mem [FX_DEPTH];

  logic                        busy_r;
  logic [FX_AW-1:0]            clr_cnt_r;
  logic [bmad_pkg::WORD_W-1:0] er_rdata_r;
  logic [bmad_pkg::WORD_W-1:0] fx_rdata_r;

  logic                        er_we;
  logic [bmad_pkg::ER_AW-1:0]  er_waddr;
  logic                        fx_we;
  logic [FX_AW-1:0]            fx_waddr;
  logic [FX_AW-1:0]            fx_raddr;
  logic [bmad_pkg::WORD_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == FX_AW'(FX_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign fx_raddr = req.fx_addr[FX_AW-1:0];

  always_comb begin
    if (busy_r) begin
      er_we    = (clr_cnt_r < FX_AW'(bmad_pkg::ER_DEPTH));
      er_waddr = clr_cnt_r[bmad_pkg::ER_AW-1:0];
      fx_we    = 1'b1;
      fx_waddr = clr_cnt_r;
      wdata    = '0;
    end else begin
      er_we    = req.er_we;
      er_waddr = req.er_addr;
      fx_we    = req.fx_we;
      fx_waddr = fx_raddr;
      wdata    = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (er_we) begin
      er_mem[er_waddr] <= wdata;
    end
    if (req.er_re && !busy_r) begin
      er_rdata_r <= er_mem[req.er_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fx_we) begin
      fx_mem[fx_waddr] <= wdata;
    end
    if (req.fx_re && !busy_r) begin
      fx_rdata_r <= fx_mem[fx_raddr];
    end
  end

  assign er_rdata = er_rdata_r;
  assign fx_rdata = fx_rdata_r;
  assign busy     = busy_r;

endmodule

[dv/testbench.sv]
module testbench;

  localparam int NUM_BANKS = 36;
  localparam int N_ITEMS = 1750;
  localparam int LIMIT = 400000;
  localparam logic [2:0] MODE_NOP = 3'd7;

  typedef struct {
    bmad_pkg::in_item_t  req;
    bit                  typed;
    bmad_pkg::out_item_t want;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bmad_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready;
  bmad_pkg::out_item_t out_data;
  logic                sink_rdy = 1'b0;
  logic                sink_hold = 1'b0;

  bit [14:0] erase_mem [0:bmad_pkg::ER_DEPTH-1];
  bit [14:0] rom_mem [0:NUM_BANKS*1024-1];
  bit [14:0] ctl_reg [0:6];
  bit [14:0] in_chan [0:7];

  bmad_pkg::out_item_t access_q[$];
  probe_t              probes[$];
  int                  err_n = 0;
  int                  accepted_n = 0;
  int                  cycle_n = 0;

  assign out_ready = sink_rdy && !sink_hold;

  banked_memory_address_decoder #(
    .NUM_FIXED_BANKS(NUM_BANKS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    err_n++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [14:0] got,
                             input logic [14:0] want);
    if (got != want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [14:0] reg_value(logic [3:0] n);
    if (n[3]) return in_chan[n[2:0]];
    if (n <= bmad_pkg::REG_BB) return ctl_reg[n[2:0]];
    return '0;
  endfunction

  function automatic bmad_pkg::out_item_t decode_access(bmad_pkg::in_item_t r);
    bmad_pkg::out_item_t res;
    logic [14:0]         a;
    logic [14:0]         v;
    logic                bk;
    int unsigned         fb;
    res = '0;
    res.region = bmad_pkg::REGION_INVALID;
    a = r.address;
    v = r.write_value[14:0];
    case (r.mode)
      bmad_pkg::MODE_READ, bmad_pkg::MODE_WRITE, bmad_pkg::MODE_FETCH: begin
        if (a <= bmad_pkg::REG_LAST && r.mode != bmad_pkg::MODE_FETCH) begin
          res.region = bmad_pkg::REGION_REG;
          if (r.mode == bmad_pkg::MODE_READ) res.read_data = reg_value(a[3:0]);
        end else if (a <= bmad_pkg::ER_LAST) begin
          bk = a[9] ? ctl_reg[bmad_pkg::REG_EB][1] : ctl_reg[bmad_pkg::REG_EB][0];
          res.region = bmad_pkg::REGION_ERASE;
          res.bank_used = {5'd0, bk};
          if (r.mode == bmad_pkg::MODE_WRITE) erase_mem[{bk, a[9:0]}] = v;
          else res.read_data = erase_mem[{bk, a[9:0]}];
        end else if (a <= bmad_pkg::MAP_LAST) begin
          if (a <= bmad_pkg::FF0_LAST) fb = 0;
          else if (a <= bmad_pkg::FF_LAST) fb = 1;
          else if (ctl_reg[bmad_pkg::REG_FB][7:0] > bmad_pkg::FB_CLAMP)
            fb = bmad_pkg::FB_CLAMP + bmad_pkg::FB_BASE;
          else fb = ctl_reg[bmad_pkg::REG_FB][7:0] + bmad_pkg::FB_BASE;
          res.region = (a <= bmad_pkg::FF_LAST) ? bmad_pkg::REGION_FIXFIX
                                                : bmad_pkg::REGION_BANKFIX;
          res.bank_used = 6'(fb);
          if (r.mode != bmad_pkg::MODE_WRITE && fb < NUM_BANKS)
            res.read_data = rom_mem[fb * 1024 + a[8:0]];
        end
      end
      bmad_pkg::MODE_REG_READ, bmad_pkg::MODE_REG_WRITE: begin
        if (a <= bmad_pkg::REG_LAST) begin
          res.region = bmad_pkg::REGION_REG;
          if (r.mode == bmad_pkg::MODE_REG_READ) begin
            res.read_data = reg_value(a[3:0]);
          end else if (a[3]) begin
            res.out_strobe = 1'b1;
            res.out_channel = a[2:0];
            res.out_value = v;
          end else if (a[3:0] <= bmad_pkg::REG_BB) begin
            ctl_reg[a[2:0]] = v;
          end
        end
      end
      bmad_pkg::MODE_ROM_LOAD: begin
        if (r.rom_index < NUM_BANKS * 1024) rom_mem[r.rom_index] = v;
      end
      bmad_pkg::MODE_SET_IN: begin
        in_chan[a[2:0]] = v;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [14:0] pick_address();
    int unsigned k;
    logic [14:0] hot_lo;
    hot_lo = 15'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    if (k < 15) return 15'($urandom_range(0, bmad_pkg::REG_LAST));
    if (k < 35) return 15'o20 + hot_lo + ($urandom_range(0, 1) ? 15'o1000 : 15'o0);
    if (k < 42) return 15'($urandom_range(15'o20, bmad_pkg::ER_LAST));
    if (k < 52) return ($urandom_range(0, 1) ? 15'o3000 : 15'o2000) + hot_lo;
    if (k < 72) return 15'o4000 + 15'($urandom_range(0, 7) << 9) + hot_lo;
    if (k < 80) return 15'($urandom_range(15'o2000, bmad_pkg::MAP_LAST));
    if (k < 90) return 15'($urandom_range(15'o10000, 15'o77777));
    return 15'($urandom);
  endfunction

  function automatic bmad_pkg::in_item_t rand_access();
    bmad_pkg::in_item_t r;
    int unsigned        k;
    r.address = pick_address();
    r.write_value = 16'($urandom);
    r.rom_index = 16'($urandom);
    k = $urandom_range(0, 99);
    if (k < 12) begin
      r.mode = bmad_pkg::MODE_ROM_LOAD;
      if (k < 10)
        r.rom_index = 16'($urandom_range(0, NUM_BANKS - 1) * 1024 + $urandom_range(0, 15));
      else if (k < 11)
        r.rom_index = 16'($urandom_range(0, NUM_BANKS * 1024 - 1));
    end else if (k < 30) begin
      r.mode = bmad_pkg::MODE_READ;
    end else if (k < 42) begin
      r.mode = bmad_pkg::MODE_WRITE;
    end else if (k < 52) begin
      r.mode = bmad_pkg::MODE_FETCH;
    end else if (k < 62) begin
      r.mode = bmad_pkg::MODE_REG_READ;
      if ($urandom_range(0, 3) != 0)
        r.address = 15'($urandom_range(0, bmad_pkg::REG_LAST));
    end else if (k < 80) begin
      r.mode = bmad_pkg::MODE_REG_WRITE;
      if (k < 72)
        r.address = 15'($urandom_range(bmad_pkg::REG_EB, bmad_pkg::REG_FB));
      else if ($urandom_range(0, 3) != 0)
        r.address = 15'($urandom_range(0, bmad_pkg::REG_LAST));
      if ($urandom_range(0, 3) != 0) r.write_value[7:0] = 8'($urandom_range(0, 40));
    end else if (k < 88) begin
      r.mode = bmad_pkg::MODE_SET_IN;
    end else if (k < 90) begin
      r.mode = MODE_NOP;
    end else begin
      r.mode = bmad_pkg::MODE_READ;
    end
    return r;
  endfunction

  task automatic add_row(input logic [2:0] m, input logic [14:0] a, input logic [15:0] v,
                         input logic [15:0] ri, input bit typed, input logic [14:0] rd,
                         input logic [2:0] rg, input logic [5:0] bk, input logic st,
                         input logic [2:0] ch, input logic [14:0] ov);
    probe_t p;
    p.req = '{mode: m, address: a, write_value: v, rom_index: ri};
    p.typed = typed;
    p.want = '{read_data: rd, region: rg, bank_used: bk, out_strobe: st,
               out_channel: ch, out_value: ov};
    probes.push_back(p);
  endtask

  initial begin
    bmad_pkg::in_item_t  req;
    bmad_pkg::out_item_t want;
    int                  gap;
    add_row(bmad_pkg::MODE_READ, 15'o0, 16'h0, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG, 6'd0,
            1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o0, 16'hFFFF, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_READ, 15'o0, 16'h0, 16'h0, 1, 15'h7FFF, bmad_pkg::REGION_REG,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_READ, 15'o0, 16'h0, 16'h0, 1, 15'h7FFF, bmad_pkg::REGION_REG, 6'd0,
            1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_WRITE, 15'o0, 16'h0ABC, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG, 6'd0,
            1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o17, 16'h1234, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG,
            6'd0, 1'b1, 3'd7, 15'h1234);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o10, 16'h8000, 16'h0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o7, 16'h7FFF, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_READ, 15'o7, 16'h0, 16'h0, 1, 15'h0, bmad_pkg::REGION_REG, 6'd0,
            1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_READ, 15'o20, 16'h0, 16'h0, 1, 15'h0, bmad_pkg::REGION_INVALID,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o77777, 16'hFFFF, 16'h0, 1, 15'h0,
            bmad_pkg::REGION_INVALID, 6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_SET_IN, 15'o77775, 16'hD555, 16'h0, 1, 15'h0,
            bmad_pkg::REGION_INVALID, 6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_READ, 15'o15, 16'h0, 16'h0, 1, 15'h5555, bmad_pkg::REGION_REG,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_WRITE, 15'o20, 16'h0101, 16'h0, 1, 15'h0, bmad_pkg::REGION_ERASE,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_FETCH, 15'o20, 16'h0, 16'h0, 1, 15'h0101, bmad_pkg::REGION_ERASE,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_FETCH, 15'o3, 16'h0, 16'h0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o3, 16'h0003, 16'h0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bmad_pkg::MODE_READ, 15'o20, 16'h0, 16'h0, 1, 15'h0, bmad_pkg::REGION_ERASE, 6'd1,
            1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_WRITE, 15'o1777, 16'h7FFF, 16'h0, 1, 15'h0, bmad_pkg::REGION_ERASE,
            6'd1, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_ROM_LOAD, 15'o0, 16'h7001, 16'd0, 1, 15'h0,
            bmad_pkg::REGION_INVALID, 6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_READ, 15'o2000, 16'h0, 16'h0, 1, 15'h7001, bmad_pkg::REGION_FIXFIX,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_ROM_LOAD, 15'o0, 16'h2222, 16'd36351, 1, 15'h0,
            bmad_pkg::REGION_INVALID, 6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_REG_WRITE, 15'o4, 16'hFFFF, 16'h0, 0, 0, 0, 0, 0, 0, 0);
    add_row(bmad_pkg::MODE_READ, 15'o7777, 16'h0, 16'h0, 1, 15'h2222,
            bmad_pkg::REGION_BANKFIX, 6'd35, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_ROM_LOAD, 15'o0, 16'h1111, 16'hFFFF, 1, 15'h0,
            bmad_pkg::REGION_INVALID, 6'd0, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_WRITE, 15'o4000, 16'h0001, 16'h0, 1, 15'h0,
            bmad_pkg::REGION_BANKFIX, 6'd35, 1'b0, 3'd0, 15'h0);
    add_row(bmad_pkg::MODE_READ, 15'o77777, 16'h0, 16'h0, 1, 15'h0, bmad_pkg::REGION_INVALID,
            6'd0, 1'b0, 3'd0, 15'h0);
    add_row(MODE_NOP, 15'o12, 16'hFFFF, 16'hFFFF, 1, 15'h0, bmad_pkg::REGION_INVALID, 6'd0,
            1'b0, 3'd0, 15'h0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_ITEMS; i++) begin
      req = (i < probes.size()) ? probes[i].req : rand_access();
      gap = ((i / 150) % 3 == 2) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= req;
      do @(posedge clk); while (!(in_valid && in_ready));
      want = decode_access(req);
      if (i < probes.size() && probes[i].typed) want = probes[i].want;
      access_q.push_back(want);
      accepted_n++;
    end
    in_valid <= 1'b0;
    while (access_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_n == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int gap;
    int taken_n;
    taken_n = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = ((taken_n / 110) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        sink_rdy <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sink_rdy <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken_n++;
    end
  end

  // hold the result side off long enough for the input to back up
  initial begin
    wait (accepted_n >= 500);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    bmad_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (access_q.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = access_q.pop_front();
        check_field("read_data", out_data.read_data, want.read_data);
        check_field("region", 15'(out_data.region), 15'(want.region));
        check_field("bank_used", 15'(out_data.bank_used), 15'(want.bank_used));
        check_field("out_strobe", 15'(out_data.out_strobe), 15'(want.out_strobe));
        check_field("out_channel", 15'(out_data.out_channel), 15'(want.out_channel));
        check_field("out_value", out_data.out_value, want.out_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n, access_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
endmodule

[filelist.f]
sv/bmad_pkg.sv
sv/bmad_regs.sv
sv/bmad_mem.sv
sv/banked_memory_address_decoder.sv
dv/testbench.sv
